/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define CAU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be true out of reset
`define CAU_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CAU_ASSERT(label, clk, rst_n, prop)
`define CAU_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// types, constants and saturation helper for the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int MAG_W    = 64;
    localparam int QUO_BITS = 33;

    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONJ = 3'd4;

    localparam logic [MAG_W-1:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [MAG_W-1:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

    // one result word
    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     ovf;
        logic                     dz;
    } res_t;

    // saturate sign and magnitude to 32 bits, msb is the overflow flag
    function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] m;
        logic             o;
        begin
            m = mag;
            o = 1'b0;
            if (neg)
            begin
                if (mag > NEG_LIMIT)
                begin
                    o = 1'b1;
                    m = NEG_LIMIT;
                end
                m = '0 - m;
            end
            else if (mag > POS_LIMIT)
            begin
                o = 1'b1;
                m = POS_LIMIT;
            end
            return {o, m[DATA_W-1:0]};
        end
    endfunction

endpackage

/* hw/rtl/cau_if.sv */
// ----------------------------------------------------------------------------
// cau channel interfaces
// valid/ready channels for operand words and result words
// ----------------------------------------------------------------------------
interface cau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] left_real;
    logic signed [31:0] left_imag;
    logic signed [31:0] right_real;
    logic signed [31:0] right_imag;

    modport source (output valid, command, left_real, left_imag, right_real, right_imag,
                    input ready);
    modport sink (input valid, command, left_real, left_imag, right_real, right_imag,
                  output ready);
endinterface

interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic               overflow;
    logic               divide_by_zero;

    modport source (output valid, result_real, result_imag, overflow, divide_by_zero,
                    input ready);
    modport sink (input valid, result_real, result_imag, overflow, divide_by_zero,
                  output ready);
endinterface

/* hw/rtl/cau_div_step.sv */
// ----------------------------------------------------------------------------
// cau_div_step
// one registered restoring division step: one quotient bit per stage
// ----------------------------------------------------------------------------
module cau_div_step (
    input  logic                           clk,
    input  logic                           en,
    input  logic [cau_pkg::MAG_W-1:0]      rem_in,
    input  logic [cau_pkg::QUO_BITS-1:0]   lo_in,
    input  logic [cau_pkg::QUO_BITS-1:0]   q_in,
    input  logic [cau_pkg::MAG_W-1:0]      den,
    output logic [cau_pkg::MAG_W-1:0]      rem_out,
    output logic [cau_pkg::QUO_BITS-1:0]   lo_out,
    output logic [cau_pkg::QUO_BITS-1:0]   q_out
);
    import cau_pkg::*;

    logic [MAG_W:0]      trial;
    logic [MAG_W:0]      diff;
    logic                ge;
    logic [MAG_W-1:0]    rem_next;
    logic [MAG_W-1:0]    rem_reg;
    logic [QUO_BITS-1:0] lo_reg;
    logic [QUO_BITS-1:0] q_reg;

    // shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_in, lo_in[QUO_BITS-1]};
        ge       = trial >= {1'b0, den};
        diff     = trial - {1'b0, den};
        rem_next = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_in[QUO_BITS-2:0], 1'b0};
            q_reg   <= {q_in[QUO_BITS-2:0], ge};
        end
    end

    assign rem_out = rem_reg;
    assign lo_out  = lo_reg;
    assign q_out   = q_reg;
endmodule

/* hw/rtl/cau_out_buf.sv */
// ----------------------------------------------------------------------------
// cau_out_buf
// two-entry output buffer that decouples the pipeline from result ready
// ----------------------------------------------------------------------------
module cau_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cau_pkg::res_t push_word,
    output logic          space,
    cau_out_if.source     result
);
    import cau_pkg::*;

    res_t       mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    res_t       head;

    assign pop   = result.valid && result.ready;
    assign space = (count_reg != 2'd2);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (!push && pop)
            count_next = count_reg - 2'd1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_word;
    end

    assign result.valid          = (count_reg != 2'd0);
    assign result.result_real    = head.re;
    assign result.result_imag    = head.im;
    assign result.overflow       = head.ovf;
    assign result.divide_by_zero = head.dz;
endmodule

/* hw/rtl/complex_arithmetic_unit_core.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// complex add, subtract, multiply, divide and conjugate in signed fixed point
// ----------------------------------------------------------------------------
// path: stages 1 to 3, the 33 one-bit division stages and the final register,
// then the output buffer, whose fill count raises result.valid
// throughput: one word per cycle unless stalled; division stages set the depth
// stalls freeze the whole pipeline, the two-entry output buffer absorbs them
// reset clears all valid bits and the buffer pointers; data regs are not reset
`include "assert_macros.svh"

module complex_arithmetic_unit_core #(
    parameter int FRACTION_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    cau_in_if.sink    operand,
    cau_out_if.source result
);
    import cau_pkg::*;

    localparam int NUM_W  = MAG_W + FRACTION_BITS;
    localparam int CMP_W  = MAG_W + QUO_BITS;
    localparam int NSTEPS = QUO_BITS;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        res_t             res;
        logic             big_re;
        logic             big_im;
        logic             neg_re;
        logic             neg_im;
        logic [MAG_W-1:0] den;
    } side_t;

    logic space;
    logic en;
    logic push;

    // stage 1: products and simple sums
    logic                    v1_reg;
    logic [CMD_W-1:0]        cmd1_reg;
    logic signed [63:0]      ac1_reg, bd1_reg, ad1_reg, bc1_reg, cc1_reg, dd1_reg;
    logic signed [DATA_W:0]  sr1_reg, si1_reg;
    logic signed [DATA_W:0]  sr1_next, si1_next;
    logic signed [DATA_W:0]  a33, b33, c33, d33;

    assign en            = space;
    assign operand.ready = en;

    assign a33 = {operand.left_real[DATA_W-1], operand.left_real};
    assign b33 = {operand.left_imag[DATA_W-1], operand.left_imag};
    assign c33 = {operand.right_real[DATA_W-1], operand.right_real};
    assign d33 = {operand.right_imag[DATA_W-1], operand.right_imag};

    always_comb
    begin
        case (operand.command)
            CMD_ADD:
            begin
                sr1_next = a33 + c33;
                si1_next = b33 + d33;
            end
            CMD_SUB:
            begin
                sr1_next = a33 - c33;
                si1_next = b33 - d33;
            end
            default:
            begin
                sr1_next = c33;
                si1_next = '0 - d33;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg <= operand.command;
            ac1_reg  <= operand.left_real * operand.right_real;
            bd1_reg  <= operand.left_imag * operand.right_imag;
            ad1_reg  <= operand.left_real * operand.right_imag;
            bc1_reg  <= operand.left_imag * operand.right_real;
            cc1_reg  <= operand.right_real * operand.right_real;
            dd1_reg  <= operand.right_imag * operand.right_imag;
            sr1_reg  <= sr1_next;
            si1_reg  <= si1_next;
        end
    end

    // stage 2: numerators in sign and magnitude, divisor, simple results
    logic                 v2_reg;
    logic [CMD_W-1:0]     cmd2_reg;
    logic                 nr2_reg, ni2_reg;
    logic [MAG_W-1:0]     mr2_reg, mi2_reg, den2_reg;
    res_t                 res2_reg;
    logic signed [MAG_W:0] num_re, num_im, abs_re, abs_im;
    logic [DATA_W:0]      sat_sr, sat_si;
    logic [DATA_W:0]      mag_sr, mag_si;
    res_t                 res2_next;

    always_comb
    begin
        if (cmd1_reg == CMD_DIV)
        begin
            num_re = {ac1_reg[63], ac1_reg} + {bd1_reg[63], bd1_reg};
            num_im = {bc1_reg[63], bc1_reg} - {ad1_reg[63], ad1_reg};
        end
        else
        begin
            num_re = {ac1_reg[63], ac1_reg} - {bd1_reg[63], bd1_reg};
            num_im = {ad1_reg[63], ad1_reg} + {bc1_reg[63], bc1_reg};
        end
        abs_re = num_re[MAG_W] ? ('0 - num_re) : num_re;
        abs_im = num_im[MAG_W] ? ('0 - num_im) : num_im;
        mag_sr = sr1_reg[DATA_W] ? ('0 - sr1_reg) : sr1_reg;
        mag_si = si1_reg[DATA_W] ? ('0 - si1_reg) : si1_reg;
        sat_sr = sat_mag(sr1_reg[DATA_W], {{(MAG_W-DATA_W-1){1'b0}}, mag_sr});
        sat_si = sat_mag(si1_reg[DATA_W], {{(MAG_W-DATA_W-1){1'b0}}, mag_si});
        res2_next.dz = 1'b0;
        case (cmd1_reg)
            CMD_ADD, CMD_SUB, CMD_CONJ:
            begin
                res2_next.re  = sat_sr[DATA_W-1:0];
                res2_next.im  = sat_si[DATA_W-1:0];
                res2_next.ovf = sat_sr[DATA_W] | sat_si[DATA_W];
            end
            default:
            begin
                res2_next.re  = '0;
                res2_next.im  = '0;
                res2_next.ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd2_reg <= cmd1_reg;
            nr2_reg  <= num_re[MAG_W];
            ni2_reg  <= num_im[MAG_W];
            mr2_reg  <= abs_re[MAG_W-1:0];
            mi2_reg  <= abs_im[MAG_W-1:0];
            den2_reg <= cc1_reg + dd1_reg;
            res2_reg <= res2_next;
        end
    end

    // stage 3: product scaling, divider setup and range check
    logic [NUM_W-1:0]     nr_sh, ni_sh;
    logic [MAG_W-1:0]     pr_sh, pi_sh;
    logic [DATA_W:0]      sat_pr, sat_pi;
    side_t                side3_next;

    logic [MAG_W-1:0]     rem_s [0:NSTEPS];
    logic [QUO_BITS-1:0]  lo_s  [0:NSTEPS];
    logic [QUO_BITS-1:0]  q_s   [0:NSTEPS];
    logic [MAG_W-1:0]     remi_s [0:NSTEPS];
    logic [QUO_BITS-1:0]  loi_s  [0:NSTEPS];
    logic [QUO_BITS-1:0]  qi_s   [0:NSTEPS];
    side_t                side_reg [0:NSTEPS];
    logic                 vs_reg   [0:NSTEPS];
    logic [MAG_W-1:0]     rem3_reg, remi3_reg;
    logic [QUO_BITS-1:0]  lo3_reg, loi3_reg;

    always_comb
    begin
        nr_sh = {mr2_reg, {FRACTION_BITS{1'b0}}};
        ni_sh = {mi2_reg, {FRACTION_BITS{1'b0}}};
        pr_sh = mr2_reg >> FRACTION_BITS;
        pi_sh = mi2_reg >> FRACTION_BITS;
        sat_pr = sat_mag(nr2_reg, pr_sh);
        sat_pi = sat_mag(ni2_reg, pi_sh);
        side3_next.cmd    = cmd2_reg;
        side3_next.res    = res2_reg;
        side3_next.neg_re = nr2_reg;
        side3_next.neg_im = ni2_reg;
        side3_next.den    = den2_reg;
        side3_next.big_re = {{(CMP_W-NUM_W){1'b0}}, nr_sh} >= {den2_reg, {QUO_BITS{1'b0}}};
        side3_next.big_im = {{(CMP_W-NUM_W){1'b0}}, ni_sh} >= {den2_reg, {QUO_BITS{1'b0}}};
        if (cmd2_reg == CMD_MUL)
        begin
            side3_next.res.re  = sat_pr[DATA_W-1:0];
            side3_next.res.im  = sat_pi[DATA_W-1:0];
            side3_next.res.ovf = sat_pr[DATA_W] | sat_pi[DATA_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side3_next;
            rem3_reg    <= {{(MAG_W-NUM_W+QUO_BITS){1'b0}}, nr_sh[NUM_W-1:QUO_BITS]};
            remi3_reg   <= {{(MAG_W-NUM_W+QUO_BITS){1'b0}}, ni_sh[NUM_W-1:QUO_BITS]};
            lo3_reg     <= nr_sh[QUO_BITS-1:0];
            loi3_reg    <= ni_sh[QUO_BITS-1:0];
        end
    end

    assign rem_s[0]  = rem3_reg;
    assign remi_s[0] = remi3_reg;
    assign lo_s[0]   = lo3_reg;
    assign loi_s[0]  = loi3_reg;
    assign q_s[0]    = '0;
    assign qi_s[0]   = '0;

    // division stages, real and imaginary lanes side by side
    genvar k;
    generate
        for (k = 0; k < NSTEPS; k++)
        begin : g_step
            cau_div_step u_re (
                .clk     (clk),
                .en      (en),
                .rem_in  (rem_s[k]),
                .lo_in   (lo_s[k]),
                .q_in    (q_s[k]),
                .den     (side_reg[k].den),
                .rem_out (rem_s[k+1]),
                .lo_out  (lo_s[k+1]),
                .q_out   (q_s[k+1])
            );
            cau_div_step u_im (
                .clk     (clk),
                .en      (en),
                .rem_in  (remi_s[k]),
                .lo_in   (loi_s[k]),
                .q_in    (qi_s[k]),
                .den     (side_reg[k].den),
                .rem_out (remi_s[k+1]),
                .lo_out  (loi_s[k+1]),
                .q_out   (qi_s[k+1])
            );

            always_ff @(posedge clk)
            begin
                if (en)
                    side_reg[k+1] <= side_reg[k];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vs_reg[k+1] <= 1'b0;
                else if (en)
                    vs_reg[k+1] <= vs_reg[k];
            end
        end
    endgenerate

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vs_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= operand.valid;
            v2_reg    <= v1_reg;
            vs_reg[0] <= v2_reg;
        end
    end

    // final stage: quotient saturation and result select
    side_t            last;
    logic [MAG_W-1:0] qr_mag, qi_mag;
    logic [DATA_W:0]  sat_qr, sat_qi;
    res_t             fin_next;
    res_t             fin_reg;
    logic             vfin_reg;

    assign last = side_reg[NSTEPS];

    always_comb
    begin
        qr_mag = last.big_re ? (64'd1 << QUO_BITS) :
                 {{(MAG_W-QUO_BITS){1'b0}}, q_s[NSTEPS]};
        qi_mag = last.big_im ? (64'd1 << QUO_BITS) :
                 {{(MAG_W-QUO_BITS){1'b0}}, qi_s[NSTEPS]};
        sat_qr = sat_mag(last.neg_re, qr_mag);
        sat_qi = sat_mag(last.neg_im, qi_mag);
        fin_next = last.res;
        if (last.cmd == CMD_DIV)
        begin
            if (last.den == '0)
            begin
                fin_next.re  = '0;
                fin_next.im  = '0;
                fin_next.ovf = 1'b0;
                fin_next.dz  = 1'b1;
            end
            else
            begin
                fin_next.re  = sat_qr[DATA_W-1:0];
                fin_next.im  = sat_qi[DATA_W-1:0];
                fin_next.ovf = sat_qr[DATA_W] | sat_qi[DATA_W];
                fin_next.dz  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fin_reg <= fin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vfin_reg <= 1'b0;
        else if (en)
            vfin_reg <= vs_reg[NSTEPS];
    end

    assign push = vfin_reg && en;

    cau_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (fin_reg),
        .space     (space),
        .result    (result)
    );

    // a zero divisor never reports saturation
    `CAU_ASSERT(a_dz_no_ovf, clk, rst_n, (vfin_reg && fin_reg.dz) |-> !fin_reg.ovf)
    // only divide words carry the zero divisor flag
    `CAU_ASSERT(a_dz_only_div, clk, rst_n, (vs_reg[NSTEPS] && last.cmd != CMD_DIV) |-> !fin_next.dz)
    // a frozen pipeline holds its final word
    `CAU_ASSERT(a_hold_fin, clk, rst_n, (!en && vfin_reg) |=> (vfin_reg && $stable(fin_reg)))
endmodule
